### hw/rtl/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg
// Shared codes and types for the sentence lock table: opcodes, status codes,
// the request token that walks the cell chain and the table write command.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int FILE_PORT_W = 32;
  localparam int SENT_W      = 16;
  localparam int OWNER_W     = 16;
  localparam int SLOT_IN_W   = 7;
  localparam int GRANT_W     = 6;
  // slot index carried on the chain; covers tables up to 1024 entries
  localparam int SLOT_W      = 10;

  localparam logic [1:0] OP_ACQUIRE  = 2'd0;
  localparam logic [1:0] OP_REL_SLOT = 2'd1;
  localparam logic [1:0] OP_REL_OWN  = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DENIED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic                   active;
    logic [1:0]             op;
    logic [FILE_PORT_W-1:0] fid;
    logic [SENT_W-1:0]      sent;
    logic [OWNER_W-1:0]     own;
    logic                   m_found;
    logic                   m_ok;
    logic [SLOT_W-1:0]      m_idx;
    logic                   f_found;
    logic [SLOT_W-1:0]      f_idx;
    logic                   hit;
  } token_t;

  typedef struct packed {
    logic                   set_en;
    logic                   clr_en;
    logic [SLOT_W-1:0]      idx;
    logic [FILE_PORT_W-1:0] fid;
    logic [SENT_W-1:0]      sent;
    logic [OWNER_W-1:0]     own;
  } wr_t;

endpackage

### hw/rtl/slt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_cell
// One lock entry. Compares the passing request token against its entry,
// updates the token and registers it before handing it to the next cell.
// ----------------------------------------------------------------------------
module slt_cell
  import slt_pkg::*;
#(
  parameter int IDX = 0,
  parameter int FW  = 32
) (
  input  logic   clk,
  input  logic   rst,
  input  token_t tok_in,
  input  wr_t    wr,
  output token_t tok_out
);

  logic              valid;
  logic [FW-1:0]     file;
  logic [SENT_W-1:0] sent;
  logic [OWNER_W-1:0] own;

  logic   file_eq;
  logic   here;
  token_t tok_next;

  assign file_eq = (file == tok_in.fid[FW-1:0]);
  assign here    = (wr.idx == SLOT_W'(IDX));

  always_comb begin
    tok_next = tok_in;
    if (tok_in.active && valid) begin
      if (tok_in.op == OP_ACQUIRE && !tok_in.m_found && file_eq && sent == tok_in.sent) begin
        tok_next.m_found = 1'b1;
        tok_next.m_ok    = (own == tok_in.own);
        tok_next.m_idx   = SLOT_W'(IDX);
      end
      if (tok_in.op == OP_QUERY && file_eq) tok_next.hit = 1'b1;
    end
    if (tok_in.active && !valid && tok_in.op == OP_ACQUIRE && !tok_in.f_found) begin
      tok_next.f_found = 1'b1;
      tok_next.f_idx   = SLOT_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.active && tok_in.op == OP_REL_OWN && valid && own == tok_in.own)
        valid <= 1'b0;
      if (wr.clr_en && here) valid <= 1'b0;
      if (wr.set_en && here) valid <= 1'b1;
    end
    if (wr.set_en && here) begin
      file <= wr.fid[FW-1:0];
      sent <= wr.sent;
      own  <= wr.own;
    end
  end

endmodule

### hw/rtl/sentence_lock_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sentence_lock_table
// Lock table of file/sentence/owner entries built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Present op, file_id, sentence, owner and slot with start high while
//   busy is low; the request is taken at that edge.
//   Release-slot completes without a walk: done pulses the cycle after the request
//   and busy never rises.
//   Acquire, release-owner and query send a token down the chain of
//   TABLE_ENTRIES cells, one cell per cycle; no new request is taken during
//   the walk, and the next request can be taken in the cycle in which done is
//   high.
//   busy is high during the walk and falls as done rises.
//   An acquire that claims a free slot writes it at the edge that raises done.
//   done is high for exactly one cycle with status, granted_slot and
//   file_locked; the receiver cannot stall, the result must be taken then.
//   Reset clears every valid bit and any request in flight at once.
// ----------------------------------------------------------------------------
module sentence_lock_table
  import slt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int FILE_ID_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             op,
  input  logic [FILE_PORT_W-1:0] file_id,
  input  logic [SENT_W-1:0]      sentence,
  input  logic [OWNER_W-1:0]     owner,
  input  logic [SLOT_IN_W-1:0]   slot,
  output logic                   done,
  output logic [1:0]             status,
  output logic [GRANT_W-1:0]     granted_slot,
  output logic                   file_locked
);

  localparam int FW = (FILE_ID_BITS > FILE_PORT_W) ? FILE_PORT_W : FILE_ID_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state;
  token_t chain [0:TABLE_ENTRIES];
  wr_t    wr;
  logic   take;
  logic   out_of_range;
  token_t tail;

  assign busy         = (state == S_SCAN);
  assign take         = start && !busy;
  assign out_of_range = (32'(slot) >= 32'(TABLE_ENTRIES));
  assign tail         = chain[TABLE_ENTRIES];

  always_comb begin
    chain[0]         = '0;
    chain[0].active  = take && (op != OP_REL_SLOT);
    chain[0].op      = op;
    chain[0].fid     = FILE_PORT_W'(file_id[FW-1:0]);
    chain[0].sent    = sentence;
    chain[0].own     = owner;
  end

  always_comb begin
    wr        = '0;
    wr.fid    = tail.fid;
    wr.sent   = tail.sent;
    wr.own    = tail.own;
    if (take && op == OP_REL_SLOT && !out_of_range) begin
      wr.clr_en = 1'b1;
      wr.idx    = SLOT_W'(slot);
    end else if (tail.active && tail.op == OP_ACQUIRE && !tail.m_found && tail.f_found) begin
      wr.set_en = 1'b1;
      wr.idx    = tail.f_idx;
    end
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    slt_cell #(.IDX(g), .FW(FW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (chain[g]),
      .wr     (wr),
      .tok_out(chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            if (op == OP_REL_SLOT) begin
              done         <= 1'b1;
              status       <= out_of_range ? ST_RANGE : ST_OK;
              granted_slot <= '0;
              file_locked  <= 1'b0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tail.active) begin
            state        <= S_IDLE;
            done         <= 1'b1;
            status       <= ST_OK;
            granted_slot <= '0;
            file_locked  <= (tail.op == OP_QUERY) && tail.hit;
            if (tail.op == OP_ACQUIRE) begin
              if (tail.m_found) begin
                if (tail.m_ok) granted_slot <= tail.m_idx[GRANT_W-1:0];
                else           status       <= ST_DENIED;
              end else if (tail.f_found) begin
                granted_slot <= tail.f_idx[GRANT_W-1:0];
              end else begin
                status <= ST_FULL;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/slt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks on request and result timing and result fields of the lock table.
// ----------------------------------------------------------------------------
module slt_checker
  import slt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic [GRANT_W-1:0] granted_slot,
  input logic               file_locked
);

  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("request dropped");

  a_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done) else $error("walk ended without result");

  a_lock: assert property (@(posedge clk) disable iff (rst)
    done && file_locked |-> status == ST_OK) else $error("locked with bad status");

  a_slot: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> granted_slot == '0) else $error("slot on failure");

  a_rst: assert property (@(posedge clk)
    rst |=> !busy && !done) else $error("not idle after reset");

endmodule

bind sentence_lock_table slt_checker u_slt_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .granted_slot(granted_slot),
  .file_locked (file_locked)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sentence_lock_table testbench
// Drives directed and random lock requests through the start/busy handshake,
// predicts every result from a behavioral copy of the lock table and checks
// each done pulse, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import slt_pkg::*;

  localparam int ENTRIES   = 64;
  localparam int WALK_WAIT = ENTRIES + 16;
  localparam int STALL_MAX = 5000;

  typedef struct {
    logic [1:0]         status;
    logic [GRANT_W-1:0] granted;
    logic               locked;
  } lock_result_t;

  class lock_scoreboard;
    bit                 held[ENTRIES];
    bit [31:0]          held_file[ENTRIES];
    bit [15:0]          held_sent[ENTRIES];
    bit [15:0]          held_owner[ENTRIES];
    lock_result_t       pending[$];
    int                 mismatches;

    function void note(logic [1:0] op, logic [31:0] fid, logic [15:0] sent,
                       logic [15:0] own, logic [6:0] slt);
      lock_result_t r;
      bit done_scan;
      r.status = ST_OK;
      r.granted = '0;
      r.locked = 1'b0;
      done_scan = 0;
      case (op)
        OP_ACQUIRE: begin
          for (int i = 0; i < ENTRIES && !done_scan; i++)
            if (held[i] && held_sent[i] == sent && held_file[i] == fid) begin
              done_scan = 1;
              if (held_owner[i] == own) r.granted = i[GRANT_W-1:0];
              else r.status = ST_DENIED;
            end
          for (int i = 0; i < ENTRIES && !done_scan; i++)
            if (!held[i]) begin
              done_scan = 1;
              held[i] = 1;
              held_file[i] = fid;
              held_sent[i] = sent;
              held_owner[i] = own;
              r.granted = i[GRANT_W-1:0];
            end
          if (!done_scan) r.status = ST_FULL;
        end
        OP_REL_SLOT: begin
          if (slt >= ENTRIES) r.status = ST_RANGE;
          else held[slt] = 0;
        end
        OP_REL_OWN: begin
          for (int i = 0; i < ENTRIES; i++)
            if (held[i] && held_owner[i] == own) held[i] = 0;
        end
        default: begin
          for (int i = 0; i < ENTRIES; i++)
            if (held[i] && held_file[i] == fid) r.locked = 1'b1;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check(logic [1:0] st, logic [GRANT_W-1:0] gs, logic fl);
      lock_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d slot %0d locked %0d",
                                       st, gs, fl);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || gs !== e.granted || fl !== e.locked) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d slot %0d locked %0d, got %0d %0d %0d",
                   e.status, e.granted, e.locked, st, gs, fl);
      end
    endfunction
  endclass

  logic                   clk = 0;
  logic                   rst = 1;
  logic                   start = 0;
  logic                   busy;
  logic [1:0]             op = OP_QUERY;
  logic [FILE_PORT_W-1:0] file_id = '0;
  logic [SENT_W-1:0]      sentence = '0;
  logic [OWNER_W-1:0]     owner = '0;
  logic [SLOT_IN_W-1:0]   slot = '0;
  logic                   done;
  logic [1:0]             status;
  logic [GRANT_W-1:0]     granted_slot;
  logic                   file_locked;

  lock_scoreboard locks = new();
  int quiet_cycles = 0;
  bit gaps_on = 1;

  sentence_lock_table #(.TABLE_ENTRIES(ENTRIES), .FILE_ID_BITS(32)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .file_id(file_id), .sentence(sentence), .owner(owner),
    .slot(slot), .done(done), .status(status), .granted_slot(granted_slot),
    .file_locked(file_locked)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done) locks.check(status, granted_slot, file_locked);
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic request(logic [1:0] o, logic [31:0] f, logic [15:0] s,
                         logic [15:0] w, logic [6:0] n);
    if (gaps_on && $urandom_range(0, 99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    file_id <= f;
    sentence <= s;
    owner <= w;
    slot <= n;
    do @(posedge clk); while (busy);
    locks.note(o, f, s, w, n);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (locks.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_file();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [15:0] pick_sent();
    case ($urandom_range(0, 9))
      0: return 16'h0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 4));
    endcase
  endfunction

  function automatic logic [15:0] pick_owner();
    case ($urandom_range(0, 9))
      0: return 16'h0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int roll;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    request(OP_QUERY, 32'hFFFF_FFFF, 16'h0, 16'h0, 7'd0);
    request(OP_REL_SLOT, 32'h0, 16'h0, 16'h0, 7'd5);
    request(OP_REL_SLOT, 32'h0, 16'h0, 16'h0, 7'd64);
    request(OP_REL_SLOT, 32'h0, 16'h0, 16'h0, 7'd127);
    request(OP_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 7'd0);
    request(OP_ACQUIRE, 32'h0, 16'h0, 16'h0, 7'd127);
    request(OP_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 7'd0);
    request(OP_ACQUIRE, 32'hFFFF_FFFF, 16'hFFFF, 16'h1234, 7'd0);
    request(OP_ACQUIRE, 32'hFFFF_FFFF, 16'h0001, 16'h1234, 7'd0);
    request(OP_QUERY, 32'hFFFF_FFFF, 16'h0, 16'h0, 7'd0);
    request(OP_QUERY, 32'h7FFF_FFFF, 16'h0, 16'h0, 7'd0);
    request(OP_REL_SLOT, 32'h0, 16'h0, 16'h0, 7'd0);
    request(OP_ACQUIRE, 32'h5555_AAAA, 16'h00AA, 16'h0, 7'd0);
    request(OP_REL_OWN, 32'h0, 16'h0, 16'h1234, 7'd0);
    request(OP_QUERY, 32'hFFFF_FFFF, 16'h0, 16'h0, 7'd0);
    request(OP_REL_OWN, 32'h0, 16'h0, 16'h0, 7'd63);
    request(OP_REL_SLOT, 32'h0, 16'h0, 16'h0, 7'd63);

    for (int k = 0; k < 1150; k++) begin
      gaps_on = !(k >= 300 && k < 500);
      if (k == 650) begin
        drain();
        @(posedge clk);
      end
      // fill the table past capacity, then keep going
      if (k == 800 || k == 1100) begin
        for (int j = 0; j < ENTRIES + 6; j++)
          request(OP_ACQUIRE, $urandom, 16'($urandom), pick_owner(), 7'($urandom));
      end
      roll = $urandom_range(0, 99);
      if (roll < 50)
        request(OP_ACQUIRE, pick_file(), pick_sent(), pick_owner(), 7'($urandom));
      else if (roll < 72)
        request(OP_REL_SLOT, $urandom, 16'($urandom), 16'($urandom),
                7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(0, ENTRIES - 1)));
      else if (roll < 80)
        request(OP_REL_OWN, $urandom, 16'($urandom), pick_owner(), 7'($urandom));
      else
        request(OP_QUERY, pick_file(), 16'($urandom), 16'($urandom), 7'($urandom));
    end

    drain();
    repeat (WALK_WAIT) @(posedge clk);
    if (locks.mismatches == 0 && locks.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
